// ----- rtl/sha256_pkg.sv -----
package sha256_pkg;

    // Operation codes carried in item.operation
    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned HASH_WORDS  = 8;
    localparam int unsigned ROUNDS      = 64;

    // Buffer positions used by the padding sequence
    localparam logic [5:0] LAST_BYTE_POS = 6'd63;
    localparam logic [5:0] LEN_BYTE_POS  = 6'd56;
    localparam logic [5:0] LAST_ROUND    = 6'd63;

    localparam logic [7:0]  PAD_MARK   = 8'h80;
    localparam logic [63:0] BLOCK_BITS = 64'd512;

    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [63:0] digest_word_pair0;
        logic [63:0] digest_word_pair1;
        logic [63:0] digest_word_pair2;
        logic [63:0] digest_word_pair3;
    } digest_t;

    localparam logic [WORD_W-1:0] INIT_HASH [HASH_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [WORD_W-1:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

// ----- rtl/sha256_hash_engine.sv -----
// SHA-256 engine over a byte stream.
// Input channel (item_valid/item_ready, payload item): an absorb transfer adds
// one message byte, a finish transfer pads the message and ends it.
// Output channel (digest_valid/digest_ready, payload digest): one 256-bit
// digest per finish, hash word 0 in the top bits of digest_word_pair0.
// The 64th absorbed byte of a block starts the compression, which runs one
// round per cycle on a single round datapath and then folds the result into
// the chaining words. item_ready is low during compression and padding.
// A finish writes one pad byte per cycle up to byte 56 (plus a second
// compression when fewer than 9 bytes are free), loads the bit length and
// compresses; the digest is registered from the final fold, then the engine
// restarts from the initial hash values.
// The digest register holds while digest_ready is low, and absorbs of the next
// message go on meanwhile; a later finish waits for that register to empty.
// Reset (rst_n, asynchronous) restores the initial hash values, an empty buffer
// and a zero bit count, and drops digest_valid.
module sha256_hash_engine
    import sha256_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    digest_valid,
    input  logic    digest_ready,
    output digest_t digest
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PAD,
        S_ROUND,
        S_UPDATE
    } state_t;

    state_t            state_reg, state_next;
    logic [5:0]        fill_reg, fill_next;
    logic [5:0]        round_reg, round_next;
    logic              finish_reg, finish_next;
    logic              wrap_reg, wrap_next;
    logic              last_reg, last_next;
    logic [63:0]       bits_reg, bits_next;
    logic [63:0]       total_reg, total_next;
    logic              out_valid_reg, out_valid_next;
    digest_t           out_reg, out_next;
    logic [WORD_W-1:0] h_reg [HASH_WORDS];
    logic [WORD_W-1:0] h_next [HASH_WORDS];
    logic [WORD_W-1:0] v_reg [HASH_WORDS];
    logic [WORD_W-1:0] v_next [HASH_WORDS];
    logic [WORD_W-1:0] w_reg [BLOCK_WORDS];
    logic [WORD_W-1:0] w_next [BLOCK_WORDS];
    logic [WORD_W-1:0] sum_w [HASH_WORDS];

    logic              byte_we;
    logic [7:0]        byte_val;
    logic [WORD_W-1:0] t1, t2, ch, maj, sched_new;

    assign item_ready   = (state_reg == S_IDLE);
    assign digest_valid = out_valid_reg;
    assign digest       = out_reg;

    // Round datapath: one SHA-256 round and one schedule word per cycle
    always_comb
    begin
        ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1  = v_reg[7] + big_sigma1(v_reg[4]) + ch + ROUND_K[round_reg] + w_reg[0];
        t2  = big_sigma0(v_reg[0]) + maj;
        sched_new = small_sigma1(w_reg[14]) + w_reg[9] + small_sigma0(w_reg[1]) + w_reg[0];
        for (int i = 0; i < HASH_WORDS; i++)
        begin
            sum_w[i] = h_reg[i] + v_reg[i];
        end
    end

    // Sequencer and next-state logic
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        round_next     = round_reg;
        finish_next    = finish_reg;
        wrap_next      = wrap_reg;
        last_next      = last_reg;
        bits_next      = bits_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        h_next         = h_reg;
        v_next         = v_reg;
        w_next         = w_reg;
        byte_we        = 1'b0;
        byte_val       = '0;

        // Drop the digest once its transfer completes
        if (out_valid_reg && digest_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                v_next     = h_reg;
                round_next = '0;
                if (item_valid)
                begin
                    byte_we   = 1'b1;
                    fill_next = fill_reg + 6'd1;
                    if (item.operation == OP_ABSORB)
                    begin
                        byte_val = item.data_byte;
                        if (fill_reg == LAST_BYTE_POS)
                        begin
                            state_next = S_ROUND;
                        end
                    end
                    else
                    begin
                        byte_val    = PAD_MARK;
                        total_next  = bits_reg + {55'b0, fill_reg, 3'b000};
                        finish_next = 1'b1;
                        last_next   = 1'b0;
                        // Length does not fit behind the pad mark: extra block
                        wrap_next   = (fill_reg >= LEN_BYTE_POS) && (fill_reg != LAST_BYTE_POS);
                        if (fill_reg == LAST_BYTE_POS)
                        begin
                            state_next = S_ROUND;
                        end
                        else
                        begin
                            state_next = S_PAD;
                        end
                    end
                end
            end

            S_PAD:
            begin
                v_next     = h_reg;
                round_next = '0;
                if (fill_reg == LEN_BYTE_POS && !wrap_reg)
                begin
                    // Load the big-endian bit length into the last two words
                    w_next[BLOCK_WORDS-2] = total_reg[63:32];
                    w_next[BLOCK_WORDS-1] = total_reg[31:0];
                    last_next             = 1'b1;
                    state_next            = S_ROUND;
                end
                else
                begin
                    byte_we   = 1'b1;
                    fill_next = fill_reg + 6'd1;
                    if (fill_reg == LAST_BYTE_POS)
                    begin
                        wrap_next  = 1'b0;
                        state_next = S_ROUND;
                    end
                end
            end

            S_ROUND:
            begin
                // Advance working variables and the schedule window
                v_next[7] = v_reg[6];
                v_next[6] = v_reg[5];
                v_next[5] = v_reg[4];
                v_next[4] = v_reg[3] + t1;
                v_next[3] = v_reg[2];
                v_next[2] = v_reg[1];
                v_next[1] = v_reg[0];
                v_next[0] = t1 + t2;
                for (int i = 0; i < BLOCK_WORDS - 1; i++)
                begin
                    w_next[i] = w_reg[i+1];
                end
                w_next[BLOCK_WORDS-1] = sched_new;
                round_next = round_reg + 6'd1;
                if (round_reg == LAST_ROUND)
                begin
                    state_next = S_UPDATE;
                end
            end

            S_UPDATE:
            begin
                if (!finish_reg)
                begin
                    h_next     = sum_w;
                    bits_next  = bits_reg + BLOCK_BITS;
                    state_next = S_IDLE;
                end
                else if (!last_reg)
                begin
                    h_next     = sum_w;
                    state_next = S_PAD;
                end
                else if (!out_valid_reg || digest_ready)
                begin
                    // Emit the digest and restart for the next message
                    out_next.digest_word_pair0 = {sum_w[0], sum_w[1]};
                    out_next.digest_word_pair1 = {sum_w[2], sum_w[3]};
                    out_next.digest_word_pair2 = {sum_w[4], sum_w[5]};
                    out_next.digest_word_pair3 = {sum_w[6], sum_w[7]};
                    out_valid_next = 1'b1;
                    h_next         = INIT_HASH;
                    bits_next      = '0;
                    fill_next      = '0;
                    finish_next    = 1'b0;
                    last_next      = 1'b0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Write one byte into the block buffer, big-endian within the word
        if (byte_we)
        begin
            w_next[fill_reg[5:2]][{~fill_reg[1:0], 3'b000} +: 8] = byte_val;
        end
    end

    // Control state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            round_reg     <= '0;
            finish_reg    <= 1'b0;
            wrap_reg      <= 1'b0;
            last_reg      <= 1'b0;
            bits_reg      <= '0;
            out_valid_reg <= 1'b0;
            h_reg         <= INIT_HASH;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            round_reg     <= round_next;
            finish_reg    <= finish_next;
            wrap_reg      <= wrap_next;
            last_reg      <= last_next;
            bits_reg      <= bits_next;
            out_valid_reg <= out_valid_next;
            h_reg         <= h_next;
        end
    end

    // Datapath registers: block buffer, working variables, length, digest
    always_ff @(posedge clk)
    begin
        w_reg     <= w_next;
        v_reg     <= v_next;
        total_reg <= total_next;
        out_reg   <= out_next;
    end

endmodule

// ----- rtl/sha256_checker.sv -----
module sha256_checker
    import sha256_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_ready,
    input item_t   item,
    input logic    digest_valid,
    input logic    digest_ready,
    input digest_t digest
);

    // Hold a stalled digest
    a_digest_hold: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && !digest_ready |=> digest_valid && $stable(digest))
        else $error("digest changed or dropped while stalled");

    // Block further items right after a finish transfer
    a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item.operation == OP_FINISH |=> !item_ready)
        else $error("engine ready right after finish");

    // Produce a digest only after a busy cycle
    a_digest_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(digest_valid) |-> $past(!item_ready))
        else $error("digest appeared without compression");

    // Produce no digest from an absorb
    a_absorb_silent: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item.operation == OP_ABSORB && !digest_valid
        |=> !digest_valid)
        else $error("digest appeared after absorb");

endmodule

bind sha256_hash_engine sha256_checker u_checker (.*);

// ----- tb/sv/sha256_digest_checker.sv -----
module sha256_digest_checker
    import sha256_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_ready,
    input  item_t       item,
    input  logic        digest_valid,
    input  logic        digest_ready,
    input  digest_t     digest,
    output int unsigned mismatches,
    output int unsigned digests_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // FIPS 180-4 round constants and initial hash value, kept apart from the RTL copy
    localparam bit [31:0] K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam bit [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    bit [31:0]   chain [8];
    bit [63:0]   bit_count;
    bit [7:0]    block_buf [64];
    int unsigned fill;
    digest_t     pending_digests [$];
    digest_t     oldest;

    function automatic bit [31:0] rotr(input bit [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Run 64 rounds over the buffered block and fold into the chaining words
    function automatic void compress_block();
        bit [31:0] w [64];
        bit [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int i = 0; i < 16; i++)
        begin
            w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
        end
        for (int i = 16; i < 64; i++)
        begin
            w[i] = (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
                 + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
        end
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
        e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
        for (int i = 0; i < 64; i++)
        begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
               + K_TABLE[i] + w[i];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
        chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    endfunction

    function automatic void restart();
        chain     = IV;
        bit_count = '0;
        fill      = 0;
    endfunction

    // Append one message byte; compress once the block is full
    function automatic void absorb_byte(input bit [7:0] value);
        block_buf[fill] = value;
        fill++;
        if (fill == 64)
        begin
            compress_block();
            bit_count += 64'd512;
            fill = 0;
        end
    endfunction

    // Pad, append the bit length, compress and return the digest of the message
    function automatic digest_t finish_message();
        bit [63:0] total;
        digest_t   result;
        total = bit_count + 64'(fill) * 64'd8;
        block_buf[fill] = PAD_MARK;
        fill++;
        // spill into a second block when the length no longer fits
        if (fill > 56)
        begin
            while (fill < 64)
            begin
                block_buf[fill] = 8'h00;
                fill++;
            end
            compress_block();
            fill = 0;
        end
        while (fill < 56)
        begin
            block_buf[fill] = 8'h00;
            fill++;
        end
        for (int i = 0; i < 8; i++)
        begin
            block_buf[56 + i] = total[63 - 8*i -: 8];
        end
        compress_block();
        result.digest_word_pair0 = {chain[0], chain[1]};
        result.digest_word_pair1 = {chain[2], chain[3]};
        result.digest_word_pair2 = {chain[4], chain[5]};
        result.digest_word_pair3 = {chain[6], chain[7]};
        restart();
        return result;
    endfunction

    function automatic void check_field(input string name, input bit [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, actual %h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart();
            pending_digests.delete();
            mismatches = 0;
            digests_outstanding <= 0;
        end
        else
        begin
            // compare each digest transfer with the oldest expected digest
            if (digest_valid && digest_ready)
            begin
                if (pending_digests.size() == 0)
                begin
                    $error("digest transfer with no finish outstanding: %h", digest);
                    mismatches++;
                end
                else
                begin
                    oldest = pending_digests.pop_front();
                    check_field("digest_word_pair0", oldest.digest_word_pair0,
                                digest.digest_word_pair0);
                    check_field("digest_word_pair1", oldest.digest_word_pair1,
                                digest.digest_word_pair1);
                    check_field("digest_word_pair2", oldest.digest_word_pair2,
                                digest.digest_word_pair2);
                    check_field("digest_word_pair3", oldest.digest_word_pair3,
                                digest.digest_word_pair3);
                end
            end
            // advance the hash state on each item transfer
            if (item_valid && item_ready)
            begin
                if (item.operation == OP_FINISH)
                    pending_digests = {pending_digests, finish_message()};
                else
                    absorb_byte(item.data_byte);
            end
            digests_outstanding <= pending_digests.size();
        end
    end

endmodule

// ----- tb/sv/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sha256_pkg::*;

    localparam int unsigned ITEM_TARGET = 1450;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        item_valid;
    logic        item_ready;
    item_t       item;
    logic        digest_valid;
    logic        digest_ready = 1'b0;
    digest_t     digest;
    int unsigned mismatches;
    int unsigned digests_outstanding;
    int unsigned items_sent = 0;
    bit          steady;

    always #1 clk = ~clk;

    sha256_hash_engine u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .digest_valid (digest_valid),
        .digest_ready (digest_ready),
        .digest       (digest)
    );

    sha256_digest_checker u_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .item_valid          (item_valid),
        .item_ready          (item_ready),
        .item                (item),
        .digest_valid        (digest_valid),
        .digest_ready        (digest_ready),
        .digest              (digest),
        .mismatches          (mismatches),
        .digests_outstanding (digests_outstanding)
    );

    // Stall the digest side at random, except during the steady stretch
    always @(posedge clk)
        digest_ready <= steady || ($urandom_range(0, 99) >= 32);

    // Offer one item and hold it until the transfer
    task automatic send_item(input logic op, input logic [7:0] value);
        item_t next_item;
        next_item.operation = op;
        next_item.data_byte = value;
        while (!steady && $urandom_range(0, 99) < 32)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= next_item;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        items_sent++;
        steady <= (items_sent >= 400) && (items_sent < 800);
    endtask

    task automatic send_message(input int unsigned len);
        for (int unsigned i = 0; i < len; i++)
        begin
            send_item(OP_ABSORB, 8'($urandom_range(0, 255)));
        end
        send_item(OP_FINISH, 8'($urandom_range(0, 255)));
    endtask

    // Hold off the sender until every expected digest has come back
    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (digests_outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int unsigned boundary_lengths [7];
        int unsigned pick;
        int unsigned len;
        bit          paused;
        boundary_lengths = '{55, 56, 63, 64, 119, 120, 128};
        paused     = 1'b0;
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;
        steady     <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty message, single extreme bytes, then "abc"
        send_item(OP_FINISH, 8'h00);
        send_item(OP_ABSORB, 8'h00);
        send_item(OP_FINISH, 8'hff);
        send_item(OP_ABSORB, 8'hff);
        send_item(OP_FINISH, 8'h00);
        send_item(OP_ABSORB, 8'h61);
        send_item(OP_ABSORB, 8'h62);
        send_item(OP_ABSORB, 8'h63);
        send_item(OP_FINISH, 8'h5a);
        drain();

        // lengths around the padding and block edges, random content
        foreach (boundary_lengths[i])
            send_message(boundary_lengths[i]);

        // random messages, mostly short or near one-block padding edges
        while (items_sent < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                len = $urandom_range(0, 7);
            else if (pick < 70)
                len = $urandom_range(52, 68);
            else if (pick < 90)
                len = $urandom_range(0, 140);
            else
                len = $urandom_range(110, 130);
            send_message(len);
            if (!paused && items_sent >= 900)
            begin
                drain();
                paused = 1'b1;
            end
        end

        drain();
        repeat (250) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/sha256_pkg.sv
rtl/sha256_hash_engine.sv
rtl/sha256_checker.sv
tb/sv/sha256_digest_checker.sv
tb/sv/tb.sv
